### design/eft_pkg.sv
// Shared types and constants for the error flag table.
// No dependencies; imported by every module of the block.
package eft_pkg;

    localparam int NUM_ENTRIES = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int LIM_W       = 7;
    localparam int MODE_W      = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_QUERY        = 4'd0,
        MODE_SET          = 4'd1,
        MODE_CLEAR        = 4'd2,
        MODE_CLR_CHECKED  = 4'd3,
        MODE_SET_INSPECT  = 4'd4,
        MODE_CLR_INSPECT  = 4'd5,
        MODE_FIRST_ACTIVE = 4'd6,
        MODE_NEXT_ACTIVE  = 4'd7,
        MODE_FIRST_UNCHK  = 4'd8,
        MODE_NEXT_UNCHK   = 4'd9,
        MODE_FIRST_CA     = 4'd10,
        MODE_NEXT_CA      = 4'd11
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // flag state at the scan pointer and the summary bits, as seen by the sequencer
    typedef struct packed {
        logic ptr_active;
        logic ptr_checked;
        logic sum_active;
        logic sum_checked;
    } scan_view_t;

    // outcome of one scan
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] found_index;
        logic             ca_any;
    } scan_res_t;

endpackage

### design/eft_flags.sv
// Flag vectors, counts and summary bits with the single-entry update logic.
// Depends on eft_pkg.
module eft_flags
    import eft_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  upd_en,
    input  logic [MODE_W-1:0]     mode,
    input  logic [IDX_W-1:0]      idx,
    input  logic                  idx_valid,
    input  logic [IDX_W-1:0]      ptr,
    output scan_view_t            view,
    output logic                  idx_active,
    output logic                  idx_checked,
    output logic                  idx_inspect,
    output logic [CNT_W-1:0]      active_cnt,
    output logic [CNT_W-1:0]      checked_cnt
);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    logic [NUM_ENTRIES-1:0] active_reg, active_next;
    logic [NUM_ENTRIES-1:0] checked_reg, checked_next;
    logic [NUM_ENTRIES-1:0] inspect_reg, inspect_next;
    logic [CNT_W-1:0]       acnt_reg, acnt_next;
    logic [CNT_W-1:0]       ccnt_reg, ccnt_next;
    logic                   sa_reg, sa_next;
    logic                   sc_reg, sc_next;

    always_comb begin
        logic [CNT_W-1:0] tmp;
        active_next  = active_reg;
        checked_next = checked_reg;
        inspect_next = inspect_reg;
        acnt_next    = acnt_reg;
        ccnt_next    = ccnt_reg;
        sa_next      = sa_reg;
        sc_next      = sc_reg;
        tmp          = ccnt_reg;
        if (upd_en && idx_valid) begin
            case (mode)
                MODE_SET: begin
                    if (!active_reg[idx]) begin
                        active_next[idx] = 1'b1;
                        if (acnt_reg != CNT_MAX) acnt_next = acnt_reg + 1'b1;
                    end
                    if (!checked_reg[idx]) begin
                        checked_next[idx] = 1'b1;
                        if (ccnt_reg != CNT_MAX) ccnt_next = ccnt_reg + 1'b1;
                    end
                    sa_next = 1'b1;
                    sc_next = 1'b1;
                end
                MODE_CLEAR: begin
                    if (active_reg[idx]) begin
                        active_next[idx] = 1'b0;
                        tmp = (acnt_reg != '0) ? acnt_reg - 1'b1 : acnt_reg;
                        acnt_next = tmp;
                        if (tmp == '0) sa_next = 1'b0;
                    end
                    if (!checked_reg[idx]) begin
                        checked_next[idx] = 1'b1;
                        if (ccnt_reg != CNT_MAX) ccnt_next = ccnt_reg + 1'b1;
                    end
                    sc_next = 1'b1;
                end
                MODE_CLR_CHECKED: begin
                    if (checked_reg[idx]) begin
                        checked_next[idx] = 1'b0;
                        if (ccnt_reg != '0) tmp = ccnt_reg - 1'b1;
                    end
                    if (tmp == '0) checked_next[idx] = 1'b0;
                    ccnt_next = tmp;
                end
                MODE_SET_INSPECT: inspect_next[idx] = 1'b1;
                MODE_CLR_INSPECT: inspect_next[idx] = 1'b0;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= '0;
            checked_reg <= '0;
            inspect_reg <= '0;
            acnt_reg    <= '0;
            ccnt_reg    <= '0;
            sa_reg      <= 1'b0;
            sc_reg      <= 1'b0;
        end else begin
            active_reg  <= active_next;
            checked_reg <= checked_next;
            inspect_reg <= inspect_next;
            acnt_reg    <= acnt_next;
            ccnt_reg    <= ccnt_next;
            sa_reg      <= sa_next;
            sc_reg      <= sc_next;
        end
    end

    assign view.ptr_active  = active_reg[ptr];
    assign view.ptr_checked = checked_reg[ptr];
    assign view.sum_active  = sa_reg;
    assign view.sum_checked = sc_reg;
    assign idx_active       = idx_valid & active_reg[idx];
    assign idx_checked      = idx_valid & checked_reg[idx];
    assign idx_inspect      = idx_valid & inspect_reg[idx];
    assign active_cnt       = acnt_reg;
    assign checked_cnt      = ccnt_reg;

endmodule

### design/eft_seq.sv
// Sequencer and shared compare unit: walks the entries one per cycle for searches
// and the checked-and-active summary. Depends on eft_pkg.
module eft_seq
    import eft_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [MODE_W-1:0]     mode,
    input  logic [IDX_W-1:0]      idx,
    input  logic [LIM_W-1:0]      lim,
    input  scan_view_t            view,
    input  logic                  out_free,
    output logic                  idle,
    output logic                  upd_en,
    output logic                  load,
    output logic [IDX_W-1:0]      ptr,
    output scan_res_t             res
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    scan_res_t        res_reg, res_next;

    logic             is_search;
    logic             gate;
    logic             cand;
    logic [LIM_W-1:0] start_pos;
    logic [LIM_W-1:0] ptr_ext;
    logic             hit;
    logic             last;

    assign is_search = (mode >= MODE_FIRST_ACTIVE) && (mode <= MODE_NEXT_CA);
    assign start_pos = mode[0] ? {1'b0, idx} + 1'b1 : '0;
    assign ptr_ext   = {1'b0, ptr_reg};
    assign last      = (ptr_ext + 1'b1) == lim;

    always_comb begin
        if (mode <= MODE_NEXT_ACTIVE) begin
            cand = view.ptr_active;
            gate = view.sum_active;
        end else if (mode <= MODE_NEXT_UNCHK) begin
            cand = ~view.ptr_checked;
            gate = view.sum_active;
        end else begin
            cand = view.ptr_checked & view.ptr_active;
            gate = view.sum_checked;
        end
    end

    assign hit = is_search & gate & cand & (ptr_ext >= start_pos) & ~res_reg.found;

    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        res_next   = res_reg;
        upd_en     = 1'b0;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                upd_en   = 1'b1;
                ptr_next = '0;
                res_next = '0;
                state_next = (lim == '0) ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN: begin
                if (hit) begin
                    res_next.found       = 1'b1;
                    res_next.found_index = ptr_reg;
                end
                if (view.ptr_active & view.ptr_checked) res_next.ca_any = 1'b1;
                if (last) begin
                    state_next = ST_FINISH;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
            res_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            res_reg   <= res_next;
        end
    end

    assign idle = (state_reg == ST_IDLE);
    assign ptr  = ptr_reg;
    assign res  = res_reg;

endmodule

### design/error_flag_table_with_search.sv
// Error flag table with search: one shared compare unit visits one entry per cycle,
// over the L entries in use (at most 64), to resolve searches and the
// checked-and-active summary; a new item is taken only once the result of the last
// is in the output register. Top level; depends on eft_pkg, eft_flags and eft_seq.
module error_flag_table_with_search
    import eft_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [LIM_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [MODE_W-1:0]    s_mode,
    input  logic [IDX_W-1:0]     s_index,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_index_valid,
    output logic                 m_entry_active,
    output logic                 m_entry_checked,
    output logic                 m_entry_inspect,
    output logic                 m_found,
    output logic [IDX_W-1:0]     m_found_index,
    output logic [CNT_W-1:0]     m_active_total,
    output logic [CNT_W-1:0]     m_checked_total,
    output logic                 m_any_active,
    output logic                 m_all_checked_ok
);

    logic [LIM_W-1:0]  entries_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              out_valid_reg;

    logic [LIM_W-1:0]  lim;
    logic              idx_valid;
    logic              idle, upd_en, load, accept;
    logic [IDX_W-1:0]  ptr;
    scan_view_t        view;
    scan_res_t         res;
    logic              idx_active, idx_checked, idx_inspect;
    logic [CNT_W-1:0]  active_cnt, checked_cnt;

    assign lim       = (entries_reg > LIM_W'(NUM_ENTRIES)) ? LIM_W'(NUM_ENTRIES) : entries_reg;
    assign idx_valid = {1'b0, idx_reg} < lim;
    assign s_ready   = idle;
    assign accept    = s_valid & idle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= LIM_W'(NUM_ENTRIES);
        end else if (cfg_wr_en) begin
            entries_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= s_mode;
            idx_reg  <= s_index;
        end
    end

    eft_flags u_flags (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .upd_en      (upd_en),
        .mode        (mode_reg),
        .idx         (idx_reg),
        .idx_valid   (idx_valid),
        .ptr         (ptr),
        .view        (view),
        .idx_active  (idx_active),
        .idx_checked (idx_checked),
        .idx_inspect (idx_inspect),
        .active_cnt  (active_cnt),
        .checked_cnt (checked_cnt)
    );

    eft_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .mode     (mode_reg),
        .idx      (idx_reg),
        .lim      (lim),
        .view     (view),
        .out_free (~out_valid_reg | m_ready),
        .idle     (idle),
        .upd_en   (upd_en),
        .load     (load),
        .ptr      (ptr),
        .res      (res)
    );

    // hold the result until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_index_valid    <= idx_valid;
            m_entry_active   <= idx_active;
            m_entry_checked  <= idx_checked;
            m_entry_inspect  <= idx_inspect;
            m_found          <= res.found;
            m_found_index    <= res.found_index;
            m_active_total   <= active_cnt;
            m_checked_total  <= checked_cnt;
            m_any_active     <= view.sum_active;
            m_all_checked_ok <= ~view.sum_checked | ~res.ca_any;
        end
    end

    assign m_valid = out_valid_reg;

    a_invalid_no_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_index_valid |-> !m_entry_active && !m_entry_checked && !m_entry_inspect)
        else $error("flags reported for an index outside the table");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_found_index == '0)
        else $error("found_index nonzero without a match");

    a_counts_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        active_cnt <= CNT_W'(NUM_ENTRIES) && checked_cnt <= CNT_W'(NUM_ENTRIES))
        else $error("entry count exceeds table size");

    a_load_after_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !load && !s_ready)
        else $error("result produced in the cycle after a transfer");

endmodule

### test/error_flag_table_with_search_tb.sv
`timescale 1ns / 100ps
// Testbench for error_flag_table_with_search: directed and random mode/index
// transfers checked against a flag-table predictor kept in this file.
// Depends on eft_pkg and the error_flag_table_with_search RTL.
module error_flag_table_with_search_tb;
    import eft_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int MAX_REPORTS    = 10;
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = MODE_NEXT_CA + 4'd1;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = '1;

    typedef struct packed {
        logic             index_valid;
        logic             entry_active;
        logic             entry_checked;
        logic             entry_inspect;
        logic             found;
        logic [IDX_W-1:0] found_index;
        logic [CNT_W-1:0] active_total;
        logic [CNT_W-1:0] checked_total;
        logic             any_active;
        logic             all_checked_ok;
    } status_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [LIM_W-1:0]     cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [MODE_W-1:0]    s_mode;
    logic [IDX_W-1:0]     s_index;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_index_valid;
    logic                 m_entry_active;
    logic                 m_entry_checked;
    logic                 m_entry_inspect;
    logic                 m_found;
    logic [IDX_W-1:0]     m_found_index;
    logic [CNT_W-1:0]     m_active_total;
    logic [CNT_W-1:0]     m_checked_total;
    logic                 m_any_active;
    logic                 m_all_checked_ok;

    // predictor copy of the flag table
    logic [NUM_ENTRIES-1:0] tbl_active;
    logic [NUM_ENTRIES-1:0] tbl_checked;
    logic [NUM_ENTRIES-1:0] tbl_inspect;
    logic [CNT_W-1:0]       n_active;
    logic [CNT_W-1:0]       n_checked;
    logic                   sum_active;
    logic                   sum_checked;
    logic [LIM_W-1:0]       cfg_limit;

    status_t pending_status[$];
    status_t last_status;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      mismatch_count;
    int      stray_count;
    int      fail_count;
    int      quiet_cycles;

    error_flag_table_with_search DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_index          (s_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_index_valid    (m_index_valid),
        .m_entry_active   (m_entry_active),
        .m_entry_checked  (m_entry_checked),
        .m_entry_inspect  (m_entry_inspect),
        .m_found          (m_found),
        .m_found_index    (m_found_index),
        .m_active_total   (m_active_total),
        .m_checked_total  (m_checked_total),
        .m_any_active     (m_any_active),
        .m_all_checked_ok (m_all_checked_ok)
    );

    always #5 aclk = ~aclk;

    function automatic status_t update_table(input logic [MODE_W-1:0] mode,
                                             input logic [IDX_W-1:0] idx);
        status_t          r;
        int               lim;
        int               start;
        logic [63:0]      lmask;
        logic [63:0]      sel;
        logic [63:0]      cand;
        logic             gate;
        lim   = (cfg_limit > NUM_ENTRIES) ? NUM_ENTRIES : int'(cfg_limit);
        lmask = (lim >= 64) ? '1 : ((64'd1 << lim) - 64'd1);
        sel   = 64'd1 << idx;
        r     = '0;
        r.index_valid = (int'(idx) < lim);
        if (r.index_valid) begin
            case (mode)
                MODE_SET: begin
                    if ((tbl_active & sel) == 0) begin
                        tbl_active |= sel;
                        if (n_active != '1) n_active++;
                    end
                    if ((tbl_checked & sel) == 0) begin
                        tbl_checked |= sel;
                        if (n_checked != '1) n_checked++;
                    end
                    sum_active  = 1'b1;
                    sum_checked = 1'b1;
                end
                MODE_CLEAR: begin
                    if ((tbl_active & sel) != 0) begin
                        tbl_active &= ~sel;
                        if (n_active != 0) n_active--;
                        if (n_active == 0) sum_active = 1'b0;
                    end
                    if ((tbl_checked & sel) == 0) begin
                        tbl_checked |= sel;
                        if (n_checked != '1) n_checked++;
                    end
                    sum_checked = 1'b1;
                end
                MODE_CLR_CHECKED: begin
                    if ((tbl_checked & sel) != 0) begin
                        tbl_checked &= ~sel;
                        if (n_checked != 0) n_checked--;
                    end
                end
                MODE_SET_INSPECT: tbl_inspect |= sel;
                MODE_CLR_INSPECT: tbl_inspect &= ~sel;
                default: ;
            endcase
        end
        if (mode >= MODE_FIRST_ACTIVE && mode <= MODE_NEXT_CA) begin
            if (mode <= MODE_NEXT_ACTIVE) begin
                cand = tbl_active;
                gate = sum_active;
            end else if (mode <= MODE_NEXT_UNCHK) begin
                cand = ~tbl_checked;
                gate = sum_active;
            end else begin
                cand = tbl_checked & tbl_active;
                gate = sum_checked;
            end
            cand  = cand & lmask;
            start = mode[0] ? int'(idx) + 1 : 0;
            if (gate) begin
                for (int i = start; i < lim; i++) begin
                    if (cand[i] && !r.found) begin
                        r.found       = 1'b1;
                        r.found_index = i[IDX_W-1:0];
                    end
                end
            end
        end
        r.entry_active   = r.index_valid & tbl_active[idx];
        r.entry_checked  = r.index_valid & tbl_checked[idx];
        r.entry_inspect  = r.index_valid & tbl_inspect[idx];
        r.active_total   = n_active;
        r.checked_total  = n_checked;
        r.any_active     = sum_active;
        r.all_checked_ok = !sum_checked || ((tbl_checked & tbl_active & lmask) == 0);
        return r;
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx);
        @(negedge aclk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        last_status = update_table(mode, idx);
        pending_status.push_back(last_status);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] value);
        wait_drained();
        repeat (4) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_limit = value;
    endtask

    task automatic test_searches();
        send_item(MODE_FIRST_ACTIVE, 6'd0);
        send_item(MODE_FIRST_UNCHK, 6'd0);
        send_item(MODE_SET, 6'd0);
        send_item(MODE_SET, 6'd63);
        send_item(MODE_FIRST_ACTIVE, 6'd17);
        send_item(MODE_NEXT_ACTIVE, 6'd0);
        send_item(MODE_NEXT_ACTIVE, 6'd63);
        send_item(MODE_FIRST_CA, 6'd0);
        send_item(MODE_NEXT_CA, 6'd62);
        send_item(MODE_FIRST_UNCHK, 6'd0);
        send_item(MODE_NEXT_UNCHK, 6'd62);
    endtask

    task automatic test_flag_updates();
        send_item(MODE_QUERY, 6'd63);
        send_item(MODE_SET, 6'd63);
        send_item(MODE_SET_INSPECT, 6'd63);
        send_item(MODE_CLR_INSPECT, 6'd63);
        send_item(MODE_SET_INSPECT, 6'd5);
        send_item(MODE_CLEAR, 6'd0);
        send_item(MODE_CLR_CHECKED, 6'd63);
        send_item(MODE_CLR_CHECKED, 6'd63);
        send_item(MODE_CLEAR, 6'd63);
        send_item(MODE_FIRST_UNCHK, 6'd0);
        send_item(MODE_SPARE_FIRST, 6'd5);
        send_item(MODE_SPARE_LAST, 6'd63);
    endtask

    task automatic test_limit_extremes();
        write_limit(7'd1);
        send_item(MODE_SET, 6'd1);
        send_item(MODE_SET, 6'd0);
        send_item(MODE_NEXT_ACTIVE, 6'd0);
        write_limit(7'd0);
        send_item(MODE_SET, 6'd0);
        send_item(MODE_FIRST_CA, 6'd0);
        write_limit(7'd127);
        send_item(MODE_QUERY, 6'd63);
        send_item(MODE_FIRST_CA, 6'd0);
    endtask

    function automatic logic [MODE_W-1:0] pick_mode();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20) return MODE_SET;
        if (roll < 32) return MODE_CLEAR;
        if (roll < 44) return MODE_CLR_CHECKED;
        if (roll < 48) return MODE_SET_INSPECT;
        if (roll < 52) return MODE_CLR_INSPECT;
        if (roll < 60) return MODE_QUERY;
        if (roll < 96) return MODE_W'($urandom_range(MODE_NEXT_CA, MODE_FIRST_ACTIVE));
        return MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
    endfunction

    task automatic test_random_traffic(input int items, input logic [LIM_W-1:0] lim,
                                       input int s_idle, input int r_idle);
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  idx;
        int                span;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        write_limit(lim);
        span = (lim > NUM_ENTRIES) ? NUM_ENTRIES : int'(lim);
        for (int n = 0; n < items; n++) begin
            mode = pick_mode();
            if (span > 0 && $urandom_range(99) < 85)
                idx = IDX_W'($urandom_range(span - 1));
            else
                idx = IDX_W'($urandom_range(NUM_ENTRIES - 1));
            // walk forward from the last hit
            if (mode >= MODE_FIRST_ACTIVE && mode <= MODE_NEXT_CA && mode[0] &&
                last_status.found && $urandom_range(1))
                idx = last_status.found_index;
            send_item(mode, idx);
            if (n == items / 2) wait_drained();
        end
    endtask

    task automatic check_field(input string name, input int want, input int got,
                               inout bit bad);
        if (want != got) begin
            if (!bad) mismatch_count++;
            bad = 1'b1;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $realtime, name, want, got);
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        status_t want;
        bit      bad;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                stray_count++;
                if (stray_count <= MAX_REPORTS)
                    $display("%0t: result transfer with no expectation", $realtime);
            end else begin
                want = pending_status.pop_front();
                bad  = 1'b0;
                check_field("index_valid", int'(want.index_valid),
                            int'(m_index_valid), bad);
                check_field("entry_active", int'(want.entry_active),
                            int'(m_entry_active), bad);
                check_field("entry_checked", int'(want.entry_checked),
                            int'(m_entry_checked), bad);
                check_field("entry_inspect", int'(want.entry_inspect),
                            int'(m_entry_inspect), bad);
                check_field("found", int'(want.found), int'(m_found), bad);
                check_field("found_index", int'(want.found_index),
                            int'(m_found_index), bad);
                check_field("active_total", int'(want.active_total),
                            int'(m_active_total), bad);
                check_field("checked_total", int'(want.checked_total),
                            int'(m_checked_total), bad);
                check_field("any_active", int'(want.any_active),
                            int'(m_any_active), bad);
                check_field("all_checked_ok", int'(want.all_checked_ok),
                            int'(m_all_checked_ok), bad);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("error_flag_table_with_search test failed");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_mode         = MODE_QUERY;
        s_index        = '0;
        m_ready        = 1'b0;
        tbl_active     = '0;
        tbl_checked    = '0;
        tbl_inspect    = '0;
        n_active       = '0;
        n_checked      = '0;
        sum_active     = 1'b0;
        sum_checked    = 1'b0;
        cfg_limit      = 7'd64;
        last_status    = '0;
        send_idle_pct  = 38;
        recv_idle_pct  = 74;
        mismatch_count = 0;
        stray_count    = 0;
        quiet_cycles   = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        test_searches();
        test_flag_updates();
        test_limit_extremes();

        test_random_traffic(270, 7'd64, 38, 74);
        test_random_traffic(270, 7'd5, 38, 74);
        test_random_traffic(150, 7'd33, 74, 38);
        test_random_traffic(120, 7'd2, 74, 38);
        test_random_traffic(260, 7'd64, 74, 38);
        test_random_traffic(100, 7'd1, 0, 0);
        test_random_traffic(200, 7'd17, 0, 0);
        test_random_traffic(230, 7'd64, 0, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        fail_count = mismatch_count + stray_count + pending_status.size();
        if (fail_count == 0)
            $display("error_flag_table_with_search test passed");
        else
            $display("error_flag_table_with_search test failed");
        $finish;
    end

endmodule

### filelist.f
design/eft_pkg.sv
design/eft_flags.sv
design/eft_seq.sv
design/error_flag_table_with_search.sv
test/error_flag_table_with_search_tb.sv
